/* rtl/bba_pkg.sv */
// Shared types, widths and helper functions of the block bitmap audit.
`default_nettype none
package bba_pkg;

	localparam int BLOCK_W           = 16;
	localparam int OFFSET_W          = 9;
	localparam int CNT_W             = 16;
	localparam int WIN_IDX_W         = 4;
	localparam int CFG_DATA_W        = 16;
	localparam int DEF_WINDOW_BLOCKS = 4096;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_CLEAR_WINDOW,
		OP_CLAIM,
		OP_COMPARE,
		OP_CLEAR_COUNTS
	} opcode_t;

	typedef enum logic {
		REG_TOTAL_BLOCKS,
		REG_WINDOW_INDEX
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

	// add up to eight, stick at the top
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
		input logic [3:0] k);
		logic [CNT_W:0] s;
		s = {1'b0, c} + (CNT_W+1)'(k);
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/bba_ifs.sv */
// Channel interfaces of the block bitmap audit: requests, results, configuration.
`default_nettype none
interface bba_req_if import bba_pkg::*; ();
	logic                valid;
	logic                ready;
	opcode_t             opcode;
	logic [BLOCK_W-1:0]  block_number;
	logic [OFFSET_W-1:0] byte_offset;
	logic [7:0]          free_map_byte;

	modport source (output valid, opcode, block_number, byte_offset, free_map_byte,
		input ready);
	modport sink (input valid, opcode, block_number, byte_offset, free_map_byte,
		output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             claim_ok;
	logic [CNT_W-1:0] shared_refs;
	logic [CNT_W-1:0] invalid_refs;
	logic [CNT_W-1:0] free_blocks;
	logic [CNT_W-1:0] used_but_free;
	logic [CNT_W-1:0] lost_blocks;
	logic             incomplete_flag;

	modport source (output valid, claim_ok, shared_refs, invalid_refs, free_blocks,
		used_but_free, lost_blocks, incomplete_flag, input ready);
	modport sink (input valid, claim_ok, shared_refs, invalid_refs, free_blocks,
		used_but_free, lost_blocks, incomplete_flag, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
	logic                  valid;
	logic                  ready;
	cfg_reg_t              index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/block_bitmap_audit.sv */
// Block bitmap audit: seen-bitmap of one window of volume blocks plus audit counters.
//
// Channels: req carries one command transaction (clear window store, claim a block,
// compare one free-map byte, clear counters). rsp returns one transaction per command
// with claim_ok and every counter as it stands after that command. cfg writes
// total_blocks (index 0) and window_index (index 1); it is always ready.
// The seen bits live in a single-port-write, registered-read memory of
// ceil(WINDOW_BLOCKS/8) bytes. A command's byte is read into a register as it is
// taken; in the execute state, once the output register is free, the byte is
// modified and written back and the result is loaded. Only after that commit is the
// next command taken. A clear-window command additionally sweeps the memory one byte
// a cycle, and no command is taken until the sweep is through.
// After reset the same sweep runs before the first request is taken; counters,
// flag and configuration reset to zero at once.
// When rsp stalls, the finished result holds in the output register while the next
// request is still taken; that request waits in its execute cycle until the output
// register frees, so nothing is lost or overwritten.
`default_nettype none
module block_bitmap_audit import bba_pkg::*; #(
	parameter int WINDOW_BLOCKS = DEF_WINDOW_BLOCKS
) (
	input  logic      clk,
	input  logic      arst_n,
	bba_cfg_if.sink   cfg,
	bba_req_if.sink   req,
	bba_rsp_if.source rsp
);

	localparam int SEEN_BYTES = (WINDOW_BLOCKS + 7) / 8;
	localparam int AW         = $clog2(SEEN_BYTES);
	localparam int START_W    = WIN_IDX_W + $clog2(WINDOW_BLOCKS);
	localparam int WW         = ((START_W > BLOCK_W) ? START_W : BLOCK_W) + 1;
	localparam int SPAN_W     = $clog2(WINDOW_BLOCKS + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(SEEN_BYTES - 1);

	// configuration
	logic [BLOCK_W-1:0]   total_q;
	logic [WIN_IDX_W-1:0] win_q;
	logic [WW-1:0]        start_c, span_c, start_q;
	logic [SPAN_W-1:0]    span_q;

	// control
	state_t        state_q, state_d;
	logic          req_acc, go, clearing, slot_free;
	logic [AW-1:0] clr_q;

	// request held for its execute cycle
	opcode_t             op_q;
	logic [BLOCK_W-1:0]  blk_q;
	logic [OFFSET_W-1:0] off_q;
	logic [7:0]          fbyte_q;
	logic [AW-1:0]       addr_q;
	logic [2:0]          bit_q;

	// memory
	logic [7:0]    seen_mem [SEEN_BYTES];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] rd_addr, mem_wa;
	logic [7:0]    mem_wd;
	logic          mem_we;
	logic [WW-1:0] claim_n, off_w;

	// counters and result
	logic [CNT_W-1:0] shared_q, invalid_q, free_q, used_free_q, lost_q;
	logic [CNT_W-1:0] shared_d, invalid_d, free_d, used_free_d, lost_d;
	logic             incomplete_q, incomplete_d;
	logic             claim_ok_q, claim_ok_d, mark_d;
	logic             rsp_valid_q;

	// execute-cycle decode
	logic [WW-1:0] blk_w, blk_rel;
	logic          invalid, in_win, dup, off_ok;
	logic [7:0]    bit_mask, vmask, free_v, uf_v, lost_v;
	logic [WW-1:0] nbit;

	//------------------------------------------------------------------
	// configuration registers and window geometry
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			win_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TOTAL_BLOCKS: total_q <= BLOCK_W'(cfg.data);
				REG_WINDOW_INDEX: win_q   <= cfg.data[WIN_IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		start_c = WW'(win_q) * WW'(WINDOW_BLOCKS);
		if (start_c >= WW'(total_q)) begin
			span_c = '0;
		end else begin
			span_c = WW'(total_q) - start_c;
			if (span_c > WW'(WINDOW_BLOCKS)) begin
				span_c = WW'(WINDOW_BLOCKS);
			end
		end
	end

	// user must alter geometry only when idle (unenforced); registered copy serves exec
	always_ff @(posedge clk) begin
		start_q <= start_c;
		span_q  <= span_c[SPAN_W-1:0];
	end

	//------------------------------------------------------------------
	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_acc) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (go) state_d = (op_q == OP_CLEAR_WINDOW) ? ST_CLEAR : ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		slot_free = !rsp_valid_q || rsp.ready;
		req.ready = (state_q == ST_IDLE);
		clearing  = (state_q == ST_CLEAR);
		go        = (state_q == ST_EXEC) && slot_free;
	end

	assign req_acc = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + AW'(1);
			end
		end
	end

	//------------------------------------------------------------------
	// request capture and memory read
	always_comb begin
		claim_n = WW'(req.block_number) - start_c;
		off_w   = WW'(req.byte_offset);
		rd_addr = (req.opcode == OP_CLAIM) ? claim_n[AW+2:3] : off_w[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q    <= req.opcode;
			blk_q   <= req.block_number;
			off_q   <= req.byte_offset;
			fbyte_q <= req.free_map_byte;
			addr_q  <= rd_addr;
			bit_q   <= claim_n[2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			seen_mem[mem_wa] <= mem_wd;
		end
		if (req_acc) begin
			rd_data_q <= seen_mem[rd_addr];
		end
	end

	//------------------------------------------------------------------
	// execute: decode against the byte read back
	always_comb begin
		blk_w    = WW'(blk_q);
		blk_rel  = blk_w - start_q;
		invalid  = (blk_q >= total_q);
		in_win   = (blk_w >= start_q) && (blk_rel < WW'(span_q));
		bit_mask = 8'h80 >> bit_q;
		dup      = |(rd_data_q & bit_mask);
		off_ok   = (WW'(off_q) < WW'(SEEN_BYTES));
		for (int i = 0; i < 8; i++) begin
			nbit         = WW'({off_q, 3'b000}) + WW'(i);
			vmask[7 - i] = off_ok && (nbit < WW'(span_q));
		end
		free_v = fbyte_q & vmask;
		uf_v   = fbyte_q & rd_data_q & vmask;
		lost_v = ~fbyte_q & ~rd_data_q & vmask;
	end

	always_comb begin
		shared_d     = shared_q;
		invalid_d    = invalid_q;
		free_d       = free_q;
		used_free_d  = used_free_q;
		lost_d       = lost_q;
		incomplete_d = incomplete_q;
		claim_ok_d   = 1'b0;
		mark_d       = 1'b0;
		unique case (op_q)
			OP_CLEAR_WINDOW: ;
			OP_CLAIM: begin
				if (invalid) begin
					incomplete_d = 1'b1;
					if (win_q == '0) invalid_d = sat_add(invalid_q, 4'd1);
				end else if (in_win && dup) begin
					shared_d = sat_add(shared_q, 4'd1);
				end else begin
					claim_ok_d = 1'b1;
					mark_d     = in_win;
				end
			end
			OP_COMPARE: begin
				free_d      = sat_add(free_q, pop8(free_v));
				used_free_d = sat_add(used_free_q, pop8(uf_v));
				lost_d      = sat_add(lost_q, pop8(lost_v));
			end
			OP_CLEAR_COUNTS: begin
				shared_d     = '0;
				invalid_d    = '0;
				free_d       = '0;
				used_free_d  = '0;
				lost_d       = '0;
				incomplete_d = 1'b0;
			end
			default: ;
		endcase
	end

	// write port: clearing sweep or claim write-back
	always_comb begin
		mem_we = clearing || (go && mark_d);
		mem_wa = clearing ? clr_q : addr_q;
		mem_wd = clearing ? 8'h00 : (rd_data_q | bit_mask);
	end

	// counters only move on commit, which needs a free output slot, so they
	// double as the held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shared_q     <= '0;
			invalid_q    <= '0;
			free_q       <= '0;
			used_free_q  <= '0;
			lost_q       <= '0;
			incomplete_q <= 1'b0;
			claim_ok_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (go) begin
				shared_q     <= shared_d;
				invalid_q    <= invalid_d;
				free_q       <= free_d;
				used_free_q  <= used_free_d;
				lost_q       <= lost_d;
				incomplete_q <= incomplete_d;
				claim_ok_q   <= claim_ok_d;
				rsp_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.claim_ok        = claim_ok_q;
	assign rsp.shared_refs     = shared_q;
	assign rsp.invalid_refs    = invalid_q;
	assign rsp.free_blocks     = free_q;
	assign rsp.used_but_free   = used_free_q;
	assign rsp.lost_blocks     = lost_q;
	assign rsp.incomplete_flag = incomplete_q;

endmodule
`default_nettype wire

/* bench/block_bitmap_audit_tb.sv */
// Self-checking testbench for block_bitmap_audit: directed, random and stall runs.
module block_bitmap_audit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	localparam int WIN_BLOCKS = DEF_WINDOW_BLOCKS;
	localparam int SEEN_BYTES = (WIN_BLOCKS + 7) / 8;
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic             claim_ok;
		logic [CNT_W-1:0] shared_refs;
		logic [CNT_W-1:0] invalid_refs;
		logic [CNT_W-1:0] free_blocks;
		logic [CNT_W-1:0] used_but_free;
		logic [CNT_W-1:0] lost_blocks;
		logic             incomplete_flag;
	} audit_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bba_cfg_if cfg_ch();
	bba_req_if req_ch();
	bba_rsp_if rsp_ch();

	block_bitmap_audit #(.WINDOW_BLOCKS(WIN_BLOCKS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [7:0]       seen_bits [SEEN_BYTES];
	logic [15:0]      vol_blocks = '0;
	logic [3:0]       win_sel = '0;
	logic [CNT_W-1:0] shared_q = '0;
	logic [CNT_W-1:0] invalid_q = '0;
	logic [CNT_W-1:0] free_q = '0;
	logic [CNT_W-1:0] used_free_q = '0;
	logic [CNT_W-1:0] lost_q = '0;
	logic             incomplete_q = 1'b0;

	audit_result_t audit_due [$];

	int errors = 0;
	int checked = 0;
	int n_claims = 0;
	int n_compares = 0;
	int n_win_clears = 0;
	int n_cnt_clears = 0;
	int n_reg_writes = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic int unsigned win_base();
		return win_sel * WIN_BLOCKS;
	endfunction

	function automatic int unsigned win_span();
		int unsigned base;
		base = win_base();
		if (base >= vol_blocks)
			return 0;
		return (vol_blocks - base > WIN_BLOCKS) ? WIN_BLOCKS : vol_blocks - base;
	endfunction

	task automatic predict_audit_step(input opcode_t op, input logic [15:0] blk,
		input logic [8:0] off, input logic [7:0] fbyte, output audit_result_t r);
		int unsigned base, span, n;
		logic [7:0] mask, s;
		int i;
		r = '0;
		base = win_base();
		span = win_span();
		case (op)
			OP_CLEAR_WINDOW: begin
				foreach (seen_bits[k])
					seen_bits[k] = '0;
			end
			OP_CLAIM: begin
				if (blk >= vol_blocks) begin
					// only window zero counts bad numbers, every window flags them
					if (win_sel == 0)
						invalid_q = bump(invalid_q);
					incomplete_q = 1'b1;
				end else if (blk < base || blk - base >= span) begin
					r.claim_ok = 1'b1;
				end else begin
					n = blk - base;
					mask = 8'h80 >> n[2:0];
					if (seen_bits[n >> 3] & mask) begin
						shared_q = bump(shared_q);
					end else begin
						seen_bits[n >> 3] = seen_bits[n >> 3] | mask;
						r.claim_ok = 1'b1;
					end
				end
			end
			OP_COMPARE: begin
				if (off < SEEN_BYTES) begin
					s = seen_bits[off];
					for (i = 0; i < 8; i++) begin
						n = off * 8 + i;
						if (n < span) begin
							mask = 8'h80 >> i;
							if (fbyte & mask) begin
								free_q = bump(free_q);
								if (s & mask)
									used_free_q = bump(used_free_q);
							end else if (!(s & mask)) begin
								lost_q = bump(lost_q);
							end
						end
					end
				end
			end
			default: begin
				shared_q = '0;
				invalid_q = '0;
				free_q = '0;
				used_free_q = '0;
				lost_q = '0;
				incomplete_q = 1'b0;
			end
		endcase
		r.shared_refs = shared_q;
		r.invalid_refs = invalid_q;
		r.free_blocks = free_q;
		r.used_but_free = used_free_q;
		r.lost_blocks = lost_q;
		r.incomplete_flag = incomplete_q;
	endtask

	task automatic note_failure(input string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("[%0t] %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got)
			note_failure($sformatf("result %0d %s: expected %0d, got %0d",
				checked, name, want, got));
	endtask

	// response side: every accepted transaction is matched against the oldest prediction
	always @(posedge clk) begin : check_rsp
		audit_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (audit_due.size() == 0) begin
				note_failure("result transaction with no command outstanding");
			end else begin
				want = audit_due.pop_front();
				checked++;
				check_field("claim_ok", 16'(want.claim_ok), 16'(rsp_ch.claim_ok));
				check_field("shared_refs", want.shared_refs, rsp_ch.shared_refs);
				check_field("invalid_refs", want.invalid_refs, rsp_ch.invalid_refs);
				check_field("free_blocks", want.free_blocks, rsp_ch.free_blocks);
				check_field("used_but_free", want.used_but_free, rsp_ch.used_but_free);
				check_field("lost_blocks", want.lost_blocks, rsp_ch.lost_blocks);
				check_field("incomplete_flag", 16'(want.incomplete_flag),
					16'(rsp_ch.incomplete_flag));
			end
		end
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// called at a falling edge; leaves valid up so back-to-back commands need no toggle
	task automatic send_cmd(input opcode_t op, input logic [15:0] blk,
		input logic [8:0] off, input logic [7:0] fbyte);
		audit_result_t r;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.block_number <= blk;
		req_ch.byte_offset <= off;
		req_ch.free_map_byte <= fbyte;
		do @(posedge clk); while (!req_ch.ready);
		predict_audit_step(op, blk, off, fbyte, r);
		audit_due.push_back(r);
		case (op)
			OP_CLEAR_WINDOW: n_win_clears++;
			OP_CLAIM:        n_claims++;
			OP_COMPARE:      n_compares++;
			default:         n_cnt_clears++;
		endcase
		@(negedge clk);
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (audit_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_TOTAL_BLOCKS)
			vol_blocks = val;
		else
			win_sel = val[3:0];
		n_reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// claims cluster near the window start so duplicates and compare hits are common
	task automatic send_random_cmd();
		int unsigned sel, base, span;
		opcode_t op;
		logic [15:0] blk;
		logic [8:0] off;
		logic [7:0] fb;
		base = win_base();
		span = win_span();
		blk = 16'($urandom);
		off = 9'($urandom);
		fb = 8'($urandom);
		sel = $urandom_range(99);
		if (sel < 3)
			op = OP_CLEAR_WINDOW;
		else if (sel < 58)
			op = OP_CLAIM;
		else if (sel < 95)
			op = OP_COMPARE;
		else
			op = OP_CLEAR_COUNTS;
		sel = $urandom_range(99);
		if (op == OP_CLAIM) begin
			if (sel < 60)
				blk = 16'(base + $urandom_range(63));
			else if (sel < 75)
				blk = 16'(base + $urandom_range(WIN_BLOCKS - 1));
			else if (sel < 90)
				blk = vol_blocks + 16'($urandom_range(3)) - 16'd2;
			else if (sel < 95)
				blk = sel[0] ? 16'hFFFF : 16'h0000;
		end else if (op == OP_COMPARE) begin
			if (sel < 60)
				off = 9'($urandom_range(7));
			else if (sel < 75 && span > 0)
				off = 9'((span - 1) >> 3);
		end
		send_cmd(op, blk, off, fb);
	endtask

	task automatic test_directed();
		// span is zero with total_blocks at reset
		send_cmd(OP_COMPARE, 16'h0000, 9'd0, 8'hFF);
		send_cmd(OP_CLAIM, 16'h0000, 9'd0, 8'h00);
		write_reg(REG_TOTAL_BLOCKS, 16'd20);
		send_cmd(OP_CLAIM, 16'd0, 9'd0, 8'h00);
		send_cmd(OP_CLAIM, 16'd19, 9'd0, 8'h00);
		send_cmd(OP_CLAIM, 16'd19, 9'd0, 8'h00);
		send_cmd(OP_CLAIM, 16'd20, 9'd0, 8'h00);
		send_cmd(OP_CLAIM, 16'hFFFF, 9'h1FF, 8'hFF);
		send_cmd(OP_COMPARE, 16'h0000, 9'd0, 8'h80);
		// straddles the end of the span
		send_cmd(OP_COMPARE, 16'hFFFF, 9'd2, 8'hFF);
		send_cmd(OP_COMPARE, 16'h0000, 9'h1FF, 8'hAA);
		send_cmd(OP_CLEAR_COUNTS, 16'h0000, 9'd0, 8'h00);
		send_cmd(OP_CLEAR_WINDOW, 16'hFFFF, 9'h1FF, 8'hFF);
		send_cmd(OP_CLAIM, 16'd19, 9'd0, 8'h00);
		write_reg(REG_TOTAL_BLOCKS, 16'd5000);
		write_reg(REG_WINDOW_INDEX, 16'd1);
		send_cmd(OP_CLAIM, 16'd100, 9'd0, 8'h00);
		send_cmd(OP_CLAIM, 16'd4100, 9'd0, 8'h00);
		send_cmd(OP_CLAIM, 16'hFFFF, 9'd0, 8'h00);
		send_cmd(OP_COMPARE, 16'h0000, 9'd0, 8'h0F);
		// last window, upper data bits must be ignored for the index
		write_reg(REG_TOTAL_BLOCKS, 16'hFFFF);
		write_reg(REG_WINDOW_INDEX, 16'hFFFF);
		send_cmd(OP_CLAIM, 16'd65534, 9'd0, 8'h00);
		send_cmd(OP_CLAIM, 16'd61440, 9'd0, 8'h00);
		send_cmd(OP_COMPARE, 16'h0000, 9'h1FF, 8'hFF);
		// window starts past the volume end
		write_reg(REG_TOTAL_BLOCKS, 16'd8000);
		write_reg(REG_WINDOW_INDEX, 16'd2);
		send_cmd(OP_COMPARE, 16'h0000, 9'd0, 8'h00);
		send_cmd(OP_CLAIM, 16'd7999, 9'd0, 8'h00);
		send_cmd(OP_CLEAR_COUNTS, 16'h0000, 9'd0, 8'h00);
	endtask

	task automatic test_random_traffic();
		int idle_tab [4] = '{0, 52, 0, 30};
		int stall_tab [4] = '{0, 0, 52, 30};
		int unsigned win, base, tot, sel;
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			repeat (3) begin
				win = ($urandom_range(99) < 30) ? 0 : $urandom_range(15);
				base = win * WIN_BLOCKS;
				sel = $urandom_range(99);
				if (sel < 70)
					tot = base + $urandom_range(1, 6000);
				else if (sel < 85)
					tot = base + $urandom_range(40);
				else
					tot = $urandom_range(65535);
				if (tot > 65535)
					tot = 65535;
				write_reg(REG_WINDOW_INDEX, 16'(($urandom_range(4095) << 4) | win));
				write_reg(REG_TOTAL_BLOCKS, 16'(tot));
				repeat (34) send_random_cmd();
			end
		end
	endtask

	task automatic test_backpressure();
		write_reg(REG_WINDOW_INDEX, 16'd0);
		write_reg(REG_TOTAL_BLOCKS, 16'd300);
		idle_pct = 0;
		stall_pct = 0;
		// output held off long enough for the input to back up
		hold_cycles = 80;
		repeat (16) send_random_cmd();
	endtask

	initial begin
		foreach (seen_bits[k])
			seen_bits[k] = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_CLEAR_WINDOW;
		req_ch.block_number = '0;
		req_ch.byte_offset = '0;
		req_ch.free_map_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TOTAL_BLOCKS;
		cfg_ch.data = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_traffic();
		test_backpressure();
		settle();
		repeat (16) @(negedge clk);
		$display("covered %0d claims, %0d free-map compares, %0d window clears, %0d counter clears",
			n_claims, n_compares, n_win_clears, n_cnt_clears);
		$display("%0d results checked over %0d register writes, incl. a long output hold-off",
			checked, n_reg_writes);
		if (errors == 0)
			$display("block_bitmap_audit verification clean");
		else
			$display("block_bitmap_audit verification failed");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("timeout: %0d results still outstanding", audit_due.size());
		$display("block_bitmap_audit verification failed");
		$finish;
	end

endmodule
